[src/dsi_pkg.sv]
// Shared package of the daily schedule interpolator.
// Holds widths, opcodes, status codes and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package dsi_pkg;

    localparam int DAY_MINUTES      = 1440;
    localparam int MAX_POINTS_DEF   = 16;
    localparam int NUM_CHANNELS_DEF = 8;
    localparam int PWM_FULL         = 10000;

    localparam int OPC_W    = 3;
    localparam int TIME_W   = 11;
    localparam int CH_W     = 3;
    localparam int PWM_W    = 14;
    localparam int CUR_W    = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int CFG_W    = 4;
    localparam int VAL_W    = 16;
    // magnitude of a level difference times a minute offset
    localparam int PROD_W   = VAL_W + TIME_W;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

    localparam logic [OPC_W-1:0] OP_NEW    = 3'd0;
    localparam logic [OPC_W-1:0] OP_WRITE  = 3'd1;
    localparam logic [OPC_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OPC_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OPC_W-1:0] OP_QUERY  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_TIME = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_POINT = 2'd3;

    typedef struct packed {
        logic                accept;
        logic                scan_start;
        logic                scan_step;
        logic                k_to_n;
        logic                insert;
        logic                remove;
        logic                clear_pts;
        logic                zero_start;
        logic                zero_step;
        logic                wr_chan;
        logic                set_status;
        logic [STATUS_W-1:0] status;
        logic                setup;
        logic                rd_a;
        logic                rd_b;
        logic                cap;
        logic                mul;
        logic                div_step;
        logic                fin;
        logic                load_out;
        logic                next_ch;
    } dsi_cmd_t;

    typedef struct packed {
        logic [OPC_W-1:0] op;
        logic             q_bad;
        logic             pt_bad;
        logic             empty;
        logic             full;
        logic             scan_done;
        logic             match;
        logic             zero_last;
        logic             div_done;
        logic             out_free;
        logic             last;
    } dsi_stat_t;

endpackage

[src/dsi_if.sv]
// Channel interfaces of the daily schedule interpolator: request, result, config.
// Depends on dsi_pkg.
`timescale 1ns / 1ps

interface dsi_req_if
    import dsi_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OPC_W-1:0]  opcode;
    logic [TIME_W-1:0] point_time;
    logic [CH_W-1:0]   channel;
    logic [PWM_W-1:0]  duty_level;
    logic [CUR_W-1:0]  current_level;

    modport source (output valid, opcode, point_time, channel, duty_level, current_level,
                    input ready);
    modport sink (input valid, opcode, point_time, channel, duty_level, current_level,
                  output ready);
endinterface

interface dsi_rsp_if
    import dsi_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CH_W-1:0]     channel_out;
    logic [PWM_W-1:0]    pwm_out;
    logic [CUR_W-1:0]    current_out;
    logic                last;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  point_count;

    modport source (output valid, channel_out, pwm_out, current_out, last, status,
                    point_count, input ready);
    modport sink (input valid, channel_out, pwm_out, current_out, last, status,
                  point_count, output ready);
endinterface

interface dsi_cfg_if
    import dsi_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] active_channels;

    modport source (output valid, active_channels, input ready);
    modport sink (input valid, active_channels, output ready);
endinterface

[src/dsi_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dsi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/dsi_datapath.sv]
// Datapath: sorted point list, level tables, scan, divider and output register.
// Depends on dsi_pkg, dsi_if and dsi_ram.
`timescale 1ns / 1ps

module dsi_datapath
    import dsi_pkg::*;
#(
    parameter int MaxPoints   = MAX_POINTS_DEF,
    parameter int NumChannels = NUM_CHANNELS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dsi_cmd_t          cmd,
    output dsi_stat_t         st,
    input  logic [OPC_W-1:0]  opcode,
    input  logic [TIME_W-1:0] point_time,
    input  logic [CH_W-1:0]   channel,
    input  logic [PWM_W-1:0]  duty_level,
    input  logic [CUR_W-1:0]  current_level,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_data,
    dsi_rsp_if.source         rsp
);

    localparam int IW  = $clog2(MaxPoints);
    localparam int KW  = $clog2(MaxPoints + 1);
    localparam int CW  = (NumChannels > 1) ? $clog2(NumChannels) : 1;
    localparam int NAW = $clog2(NumChannels + 1);
    localparam int AW  = $clog2(MaxPoints * NumChannels);
    localparam int DCW = $clog2(PROD_W + 1);

    // latched request
    logic [OPC_W-1:0]  op_reg;
    logic [TIME_W-1:0] t_reg;
    logic [CH_W-1:0]   ch_reg;
    logic [PWM_W-1:0]  pl_reg;
    logic [CUR_W-1:0]  cl_reg;
    logic [CFG_W-1:0]  act_reg;

    // point list
    logic [TIME_W-1:0] times_reg [MaxPoints];
    logic [IW-1:0]     order_reg [MaxPoints];
    logic [KW-1:0]     n_reg;
    logic [KW-1:0]     k_reg;
    logic [KW-1:0]     pos_reg;
    logic              match_reg;
    logic [TIME_W-1:0] prev_time_reg;
    logic [TIME_W-1:0] cur_time_reg;
    logic [IW-1:0]     prev_slot_reg;
    logic [IW-1:0]     cur_slot_reg;
    logic [IW-1:0]     kidx;
    logic              scan_done;
    logic [CW-1:0]     z_reg;

    // segment
    logic              use_a_reg;
    logic [IW-1:0]     slot_a_reg;
    logic [IW-1:0]     slot_b_reg;
    logic [TIME_W-1:0] num_reg;
    logic [TIME_W-1:0] den_reg;

    // per-channel lanes: 0 duty, 1 current
    logic [VAL_W-1:0]  a_reg    [2];
    logic [VAL_W-1:0]  b_reg    [2];
    logic              neg_reg  [2];
    logic [PROD_W-1:0] prod_reg [2];
    logic [PROD_W-1:0] quo_reg  [2];
    logic [TIME_W-1:0] rem_reg  [2];
    logic [TIME_W:0]   rem_s    [2];
    logic              qbit     [2];
    logic [DCW-1:0]    div_cnt_reg;
    logic [VAL_W-1:0]  res_reg  [2];

    logic [CW-1:0]       c_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [NAW-1:0]      na;
    logic                last_q;

    // table memories
    logic             we;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr;
    logic [PWM_W-1:0] pwm_wdata;
    logic [CUR_W-1:0] cur_wdata;
    logic [PWM_W-1:0] pwm_rdata;
    logic [CUR_W-1:0] cur_rdata;

    // output register
    logic                out_valid_reg;
    logic [CH_W-1:0]     out_ch_reg;
    logic [PWM_W-1:0]    out_pwm_reg;
    logic [CUR_W-1:0]    out_cur_reg;
    logic                out_last_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [COUNT_W-1:0]  out_count_reg;

    function automatic logic [AW-1:0] tab_addr(input logic [IW-1:0] slot,
                                               input logic [CW-1:0] ch);
        tab_addr = AW'(AW'(slot) * AW'(NumChannels) + AW'(ch));
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg <= opcode;
            t_reg  <= point_time;
            ch_reg <= channel;
            pl_reg <= duty_level;
            cl_reg <= current_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= ACTIVE_RESET;
        end
        else if (cfg_we)
        begin
            act_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (act_reg == '0)
        begin
            na = NAW'(1);
        end
        else if (int'(act_reg) > NumChannels)
        begin
            na = NAW'(NumChannels);
        end
        else
        begin
            na = NAW'(act_reg);
        end
    end

    assign kidx      = k_reg[IW-1:0];
    assign scan_done = (k_reg == n_reg) || (times_reg[kidx] >= t_reg);
    assign last_q    = (NAW'(c_reg) == na - NAW'(1));

    // shift the sorted list on insert and remove
    for (genvar g = 0; g < MaxPoints; g++)
    begin : g_ent
        localparam int PRV = (g > 0) ? g - 1 : 0;
        localparam int NXT = (g + 1 < MaxPoints) ? g + 1 : g;

        always_ff @(posedge clk)
        begin
            if (cmd.insert)
            begin
                if (KW'(g) == pos_reg)
                begin
                    times_reg[g] <= t_reg;
                end
                else if (KW'(g) > pos_reg && KW'(g) <= n_reg)
                begin
                    times_reg[g] <= times_reg[PRV];
                end
            end
            else if (cmd.remove)
            begin
                if (KW'(g) >= pos_reg && KW'(g + 1) < n_reg)
                begin
                    times_reg[g] <= times_reg[NXT];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                order_reg[g] <= IW'(g);
            end
            else if (cmd.insert)
            begin
                if (KW'(g) == pos_reg)
                begin
                    order_reg[g] <= order_reg[kidx];
                end
                else if (KW'(g) > pos_reg && KW'(g) <= n_reg)
                begin
                    order_reg[g] <= order_reg[PRV];
                end
            end
            else if (cmd.remove)
            begin
                // recycle the freed slot just past the end of the list
                if (KW'(g + 1) == n_reg)
                begin
                    order_reg[g] <= cur_slot_reg;
                end
                else if (KW'(g) >= pos_reg && KW'(g + 1) < n_reg)
                begin
                    order_reg[g] <= order_reg[NXT];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= '0;
        end
        else if (cmd.insert)
        begin
            n_reg <= n_reg + KW'(1);
        end
        else if (cmd.remove)
        begin
            n_reg <= n_reg - KW'(1);
        end
        else if (cmd.clear_pts)
        begin
            n_reg <= '0;
        end
    end

    // scan, zero pass and segment setup
    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            k_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            if (scan_done)
            begin
                pos_reg      <= k_reg;
                match_reg    <= (k_reg < n_reg) && (times_reg[kidx] == t_reg);
                cur_time_reg <= times_reg[kidx];
                cur_slot_reg <= order_reg[kidx];
            end
            else
            begin
                prev_time_reg <= times_reg[kidx];
                prev_slot_reg <= order_reg[kidx];
                k_reg         <= k_reg + KW'(1);
            end
        end
        else if (cmd.k_to_n)
        begin
            k_reg <= n_reg;
        end

        if (cmd.insert)
        begin
            cur_slot_reg <= order_reg[kidx];
            z_reg        <= '0;
        end
        else if (cmd.zero_start)
        begin
            z_reg <= '0;
        end
        else if (cmd.zero_step)
        begin
            z_reg <= z_reg + CW'(1);
        end

        if (cmd.setup)
        begin
            use_a_reg  <= 1'b0;
            slot_a_reg <= prev_slot_reg;
            if (n_reg == KW'(1))
            begin
                slot_b_reg <= (pos_reg == '0) ? cur_slot_reg : prev_slot_reg;
                num_reg    <= TIME_W'(1);
                den_reg    <= TIME_W'(1);
            end
            else if (pos_reg == '0)
            begin
                // ramp up from zero at midnight
                slot_b_reg <= cur_slot_reg;
                num_reg    <= t_reg;
                den_reg    <= (cur_time_reg == '0) ? TIME_W'(1) : cur_time_reg;
            end
            else if (pos_reg == n_reg)
            begin
                // ramp down to zero at the end of the day
                slot_b_reg <= prev_slot_reg;
                num_reg    <= TIME_W'(DAY_MINUTES) - t_reg;
                den_reg    <= TIME_W'(DAY_MINUTES) - prev_time_reg;
            end
            else
            begin
                use_a_reg  <= 1'b1;
                slot_b_reg <= cur_slot_reg;
                num_reg    <= t_reg - prev_time_reg;
                den_reg    <= cur_time_reg - prev_time_reg;
            end
        end
    end

    // table access
    always_comb
    begin
        we        = 1'b0;
        waddr     = tab_addr(cur_slot_reg, z_reg);
        pwm_wdata = '0;
        cur_wdata = '0;
        if (cmd.zero_step)
        begin
            we = 1'b1;
        end
        else if (cmd.wr_chan && int'(ch_reg) < NumChannels)
        begin
            we        = 1'b1;
            waddr     = tab_addr(cur_slot_reg, CW'(ch_reg));
            pwm_wdata = (int'(pl_reg) > PWM_FULL) ? PWM_W'(PWM_FULL) : pl_reg;
            cur_wdata = cl_reg;
        end
        raddr = cmd.rd_a ? tab_addr(slot_a_reg, c_reg) : tab_addr(slot_b_reg, c_reg);
    end

    dsi_ram #(.WIDTH(PWM_W), .DEPTH(MaxPoints * NumChannels)) u_pwm_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (pwm_wdata),
        .raddr (raddr),
        .rdata (pwm_rdata)
    );

    dsi_ram #(.WIDTH(CUR_W), .DEPTH(MaxPoints * NumChannels)) u_cur_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (cur_wdata),
        .raddr (raddr),
        .rdata (cur_rdata)
    );

    // restoring divider, one quotient bit per cycle per lane
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            rem_s[l] = {rem_reg[l], prod_reg[l][PROD_W-1]};
            qbit[l]  = (rem_s[l] >= {1'b0, den_reg});
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_b)
        begin
            a_reg[0] <= use_a_reg ? VAL_W'(pwm_rdata) : '0;
            a_reg[1] <= use_a_reg ? cur_rdata : '0;
        end
        if (cmd.cap)
        begin
            b_reg[0] <= VAL_W'(pwm_rdata);
            b_reg[1] <= cur_rdata;
        end
        for (int l = 0; l < 2; l++)
        begin
            if (cmd.mul)
            begin
                neg_reg[l]  <= (b_reg[l] < a_reg[l]);
                prod_reg[l] <= PROD_W'((b_reg[l] < a_reg[l]) ? a_reg[l] - b_reg[l]
                                                              : b_reg[l] - a_reg[l])
                               * PROD_W'(num_reg);
                rem_reg[l]  <= '0;
                quo_reg[l]  <= '0;
            end
            else if (cmd.div_step)
            begin
                rem_reg[l]  <= qbit[l] ? TIME_W'(rem_s[l] - {1'b0, den_reg})
                                       : rem_s[l][TIME_W-1:0];
                prod_reg[l] <= {prod_reg[l][PROD_W-2:0], 1'b0};
                quo_reg[l]  <= {quo_reg[l][PROD_W-2:0], qbit[l]};
            end
        end
        if (cmd.mul)
        begin
            div_cnt_reg <= DCW'(PROD_W);
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg - DCW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 2; l++)
        begin
            if (cmd.accept)
            begin
                res_reg[l] <= '0;
            end
            else if (cmd.fin)
            begin
                res_reg[l] <= neg_reg[l] ? a_reg[l] - quo_reg[l][VAL_W-1:0]
                                         : a_reg[l] + quo_reg[l][VAL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg      <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            if (cmd.accept)
            begin
                c_reg <= '0;
            end
            else if (cmd.next_ch)
            begin
                c_reg <= c_reg + CW'(1);
            end
            if (cmd.accept)
            begin
                status_reg <= ST_OK;
            end
            else if (cmd.set_status)
            begin
                status_reg <= cmd.status;
            end
        end
    end

    // result register: hold until the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_ch_reg     <= CH_W'(c_reg);
            out_pwm_reg    <= res_reg[0][PWM_W-1:0];
            out_cur_reg    <= res_reg[1];
            out_last_reg   <= (op_reg == OP_QUERY) ? last_q : 1'b1;
            out_status_reg <= status_reg;
            out_count_reg  <= COUNT_W'(n_reg);
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.channel_out = out_ch_reg;
    assign rsp.pwm_out     = out_pwm_reg;
    assign rsp.current_out = out_cur_reg;
    assign rsp.last        = out_last_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.point_count = out_count_reg;

    always_comb
    begin
        st.op        = op_reg;
        st.q_bad     = (int'(t_reg) > DAY_MINUTES);
        st.pt_bad    = (int'(t_reg) >= DAY_MINUTES);
        st.empty     = (n_reg == '0);
        st.full      = (int'(n_reg) >= MaxPoints);
        st.scan_done = scan_done;
        st.match     = match_reg;
        st.zero_last = (int'(z_reg) == NumChannels - 1);
        st.div_done  = (div_cnt_reg == '0);
        st.out_free  = !out_valid_reg || rsp.ready;
        st.last      = (op_reg == OP_QUERY) ? last_q : 1'b1;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(n_reg) <= MaxPoints)
        else $error("point count beyond table size");

    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (n_reg >= KW'(2)) |-> (times_reg[0] < times_reg[1]))
        else $error("point list not sorted");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |=> (n_reg == KW'($past(n_reg) + KW'(1))))
        else $error("insert did not grow the list");

    a_fin_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |-> (div_cnt_reg == '0))
        else $error("result taken before division finished");

endmodule

[src/dsi_ctrl.sv]
// Controller state machine: sequences scan, table updates and per-channel work.
// Depends on dsi_pkg.
`timescale 1ns / 1ps

module dsi_ctrl
    import dsi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  dsi_stat_t st,
    output dsi_cmd_t  cmd
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DISPATCH = 5'd1;
    localparam logic [4:0] S_SCAN     = 5'd2;
    localparam logic [4:0] S_DECIDE   = 5'd3;
    localparam logic [4:0] S_FREE     = 5'd4;
    localparam logic [4:0] S_ZERO     = 5'd5;
    localparam logic [4:0] S_RD_A     = 5'd6;
    localparam logic [4:0] S_RD_B     = 5'd7;
    localparam logic [4:0] S_CAP      = 5'd8;
    localparam logic [4:0] S_MUL      = 5'd9;
    localparam logic [4:0] S_DIV      = 5'd10;
    localparam logic [4:0] S_FIN      = 5'd11;
    localparam logic [4:0] S_EMIT     = 5'd12;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic       zq_reg;
    logic       zq_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        zq_next    = zq_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    zq_next    = 1'b0;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (st.op)
                    OP_QUERY:
                    begin
                        if (st.q_bad)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_BAD_TIME;
                            zq_next        = 1'b1;
                            state_next     = S_EMIT;
                        end
                        else if (st.empty)
                        begin
                            zq_next    = 1'b1;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    OP_NEW, OP_WRITE, OP_REMOVE:
                    begin
                        if (st.pt_bad)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_BAD_TIME;
                            state_next     = S_EMIT;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cmd.clear_pts = 1'b1;
                        state_next    = S_EMIT;
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (st.scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                case (st.op)
                    OP_QUERY:
                    begin
                        cmd.setup  = 1'b1;
                        state_next = S_RD_A;
                    end
                    OP_NEW:
                    begin
                        if (st.match)
                        begin
                            cmd.zero_start = 1'b1;
                            state_next     = S_ZERO;
                        end
                        else if (st.full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_FULL;
                            state_next     = S_EMIT;
                        end
                        else
                        begin
                            cmd.k_to_n = 1'b1;
                            state_next = S_FREE;
                        end
                    end
                    OP_WRITE:
                    begin
                        if (st.match)
                        begin
                            cmd.wr_chan = 1'b1;
                        end
                        else
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_NO_POINT;
                        end
                        state_next = S_EMIT;
                    end
                    OP_REMOVE:
                    begin
                        if (st.match)
                        begin
                            cmd.remove = 1'b1;
                        end
                        else
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_NO_POINT;
                        end
                        state_next = S_EMIT;
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_FREE:
            begin
                cmd.insert = 1'b1;
                state_next = S_ZERO;
            end
            S_ZERO:
            begin
                cmd.zero_step = 1'b1;
                if (st.zero_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_RD_A:
            begin
                cmd.rd_a   = 1'b1;
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                cmd.rd_b   = 1'b1;
                state_next = S_CAP;
            end
            S_CAP:
            begin
                cmd.cap    = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (st.div_done)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // hold until the result register frees up
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (st.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.next_ch = 1'b1;
                        state_next  = zq_reg ? S_EMIT : S_RD_A;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            zq_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            zq_reg    <= zq_next;
        end
    end

endmodule

[src/daily_schedule_interpolator.sv]
// Top level of the daily schedule interpolator.
// Depends on dsi_pkg, dsi_if, dsi_ctrl and dsi_datapath.
//
// Usage: requests arrive on req (opcode, point_time, channel, duty_level,
// current_level) and are taken one at a time; req.ready is high only while
// the controller is idle. Results leave on rsp, one transfer per result, with
// last marking the final result of a request. cfg writes active_channels
// and is always ready; write it only while no request is in flight.
// Clear, bad times and unused opcodes go from dispatch straight to the
// result. Other point operations first scan the list up to the point's
// position; a new point then has its levels zeroed on every channel, after
// an insert step when the point is not yet in the list. A query scans the
// list, then works through each active channel: two table reads and a
// capture, one multiply, a 27-step restoring divider run on both levels in
// parallel, a final add or subtract and the result load. A query with a bad
// time or no points emits one result per cycle while rsp is not stalled.
// The next request is taken the cycle after the last result is loaded.
// Reset clears the point list and sets active_channels to 8; table
// contents are not cleared, since every point is zeroed when created.
// A stall on rsp holds the result register and the controller waits.
`timescale 1ns / 1ps

module daily_schedule_interpolator
    import dsi_pkg::*;
#(
    parameter int MAX_POINTS   = MAX_POINTS_DEF,
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    dsi_req_if.sink   req,
    dsi_rsp_if.source rsp,
    dsi_cfg_if.sink   cfg
);

    dsi_cmd_t  cmd;
    dsi_stat_t st;
    logic      ready;

    assign req.ready = ready;
    assign cfg.ready = 1'b1;

    dsi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (ready),
        .st        (st),
        .cmd       (cmd)
    );

    dsi_datapath #(
        .MaxPoints   (MAX_POINTS),
        .NumChannels (NUM_CHANNELS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .opcode        (req.opcode),
        .point_time    (req.point_time),
        .channel       (req.channel),
        .duty_level    (req.duty_level),
        .current_level (req.current_level),
        .cfg_we        (cfg.valid),
        .cfg_data      (cfg.active_channels),
        .rsp           (rsp)
    );

endmodule
